// ===== src/u8u2_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u2_pkg
// Shared types and constants for the UTF-8 to UCS-2 path decoder.
// ----------------------------------------------------------------------------
package u8u2_pkg;

  localparam logic [15:0] BACKSLASH = 16'h005C;
  localparam logic [15:0] SLASH     = 16'h002F;

  // Result queue sizing: two slots for the item in the input register, two
  // for the one being accepted, the rest absorbs output stalls.
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [15:0] code;
    logic        last;
  } unit_t;

  // Up to two units produced by one byte, in order u0 then u1.
  typedef struct packed {
    logic [1:0] num;
    unit_t      u0;
    unit_t      u1;
  } push_t;

endpackage

// ===== src/utf8_to_ucs2_path_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_ucs2_path_decoder_top
// Streams NUL-terminated UTF-8 bytes into 16-bit code units, optionally with
// path rules (leading backslash, '/' to backslash, repeated backslash dropped).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/byte_in moves one byte per transfer; a
//   zero byte ends the string and yields a final unit 0 with last_unit set.
//   Output channel out_valid/out_stall/code_unit/last_unit moves one unit per
//   transfer. Each byte gives zero, one or two units.
//   Throughput: one byte per cycle while in_stall is low; a byte that gives two
//   units costs two output transfers, absorbed by an 8-entry result queue.
//   Each byte is held in the input register, then decoded and written into
//   the queue; the queue head drives the output combinationally.
//   in_stall rises when the queue could not take two units for each byte
//   still to be decoded, the one in the input register and a new one; it
//   depends only on queue fill and input register occupancy.
//   When the receiver stalls, the head unit holds and the queue fills.
//   path_mode is written through cfg_we/cfg_data, by the user only while the
//   block is idle; the block itself does not enforce this. Synchronous reset
//   empties the queue, clears path_mode and starts a new string.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_path_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_unit,
  output logic        last_unit
);
  import u8u2_pkg::*;

  logic             path_mode;
  logic             in_full;
  logic [7:0]       in_byte;
  logic             in_xfer;
  push_t            push;
  unit_t            out_unit;
  logic [CNT_W-1:0] count;

  // hold off while the queue might not fit the in-flight byte plus a new one
  assign in_stall = in_full ? (32'(count) > FIFO_DEPTH - 4)
                            : (32'(count) > FIFO_DEPTH - 2);
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      path_mode <= 1'b0;
      in_full   <= 1'b0;
    end else begin
      if (cfg_we) path_mode <= cfg_data;
      in_full <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) in_byte <= byte_in;
  end

  u8u2_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .fire      (in_full),
    .byte_val  (in_byte),
    .path_mode (path_mode),
    .push      (push)
  );

  u8u2_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_unit  (out_unit),
    .count     (count)
  );

  assign code_unit = out_unit.code;
  assign last_unit = out_unit.last;

endmodule

// ===== src/u8u2_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u2_decode
// Per-byte UTF-8 sequence decoder with path rules; holds the string state and
// produces up to two code units for each byte.
// ----------------------------------------------------------------------------
module u8u2_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [7:0]      byte_val,
  input  logic            path_mode,
  output u8u2_pkg::push_t push
);
  import u8u2_pkg::*;

  logic [15:0] char_accum, char_accum_next;
  logic [2:0]  bytes_left, bytes_left_next;
  logic        string_start, string_start_next;
  logic        prev_backslash, prev_backslash_next;

  logic [15:0] acc_shift;
  logic [15:0] ch;
  logic        ch_valid;
  logic        pb;
  logic        is_cont;
  unit_t       unit;

  assign acc_shift = {char_accum[9:0], byte_val[5:0]};
  assign is_cont   = (byte_val[7:6] == 2'b10);

  always_comb begin
    char_accum_next     = char_accum;
    bytes_left_next     = bytes_left;
    string_start_next   = string_start;
    prev_backslash_next = prev_backslash;
    push                = '0;
    pb                  = prev_backslash;
    ch                  = 16'h0000;
    ch_valid            = 1'b0;
    unit                = '0;
    if (fire) begin
      if (string_start) begin
        string_start_next = 1'b0;
        if (path_mode) begin
          push.u0  = '{code: BACKSLASH, last: 1'b0};
          push.num = 2'd1;
          pb       = 1'b1;
        end
      end
      prev_backslash_next = pb;
      if (byte_val == 8'h00) begin
        // terminator: drop any partial sequence, re-arm for the next string
        char_accum_next     = 16'h0000;
        bytes_left_next     = 3'd0;
        prev_backslash_next = 1'b0;
        string_start_next   = 1'b1;
        unit                = '{code: 16'h0000, last: 1'b1};
        if (push.num == 2'd0) push.u0 = unit;
        else                  push.u1 = unit;
        push.num = push.num + 2'd1;
      end else begin
        if (bytes_left != 3'd0 && is_cont) begin
          char_accum_next = acc_shift;
          bytes_left_next = bytes_left - 3'd1;
          if (bytes_left == 3'd1) begin
            ch_valid = 1'b1;
            ch       = acc_shift;
          end
        end else begin
          // broken sequence: discard it, then treat the byte as a new lead
          if (bytes_left != 3'd0) begin
            char_accum_next = 16'h0000;
            bytes_left_next = 3'd0;
          end
          priority if (!byte_val[7]) begin
            ch_valid = 1'b1;
            ch       = {8'h00, byte_val};
          end else if (byte_val[7:5] == 3'b110) begin
            char_accum_next = {11'h000, byte_val[4:0]};
            bytes_left_next = 3'd1;
          end else if (byte_val[7:4] == 4'b1110) begin
            char_accum_next = {12'h000, byte_val[3:0]};
            bytes_left_next = 3'd2;
          end else if (byte_val[7:3] == 5'b11110) begin
            char_accum_next = {13'h0000, byte_val[2:0]};
            bytes_left_next = 3'd3;
          end else if (byte_val[7:2] == 6'b111110) begin
            char_accum_next = {14'h0000, byte_val[1:0]};
            bytes_left_next = 3'd4;
          end else if (byte_val[7:1] == 7'b1111110) begin
            char_accum_next = {15'h0000, byte_val[0]};
            bytes_left_next = 3'd5;
          end else begin
            // invalid lead: drop
          end
        end
        if (ch_valid) begin
          if (path_mode && ch == SLASH) ch = BACKSLASH;
          if (!(path_mode && ch == BACKSLASH && pb)) begin
            prev_backslash_next = (ch == BACKSLASH);
            unit                = '{code: ch, last: 1'b0};
            if (push.num == 2'd0) push.u0 = unit;
            else                  push.u1 = unit;
            push.num = push.num + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_accum     <= 16'h0000;
      bytes_left     <= 3'd0;
      string_start   <= 1'b1;
      prev_backslash <= 1'b0;
    end else begin
      char_accum     <= char_accum_next;
      bytes_left     <= bytes_left_next;
      string_start   <= string_start_next;
      prev_backslash <= prev_backslash_next;
    end
  end

  a_bytes_left_range: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= 3'd5)
    else $error("bytes_left out of range");

  a_term_rearm: assert property (@(posedge clk) disable iff (rst)
    (fire && byte_val == 8'h00) |=>
      (string_start && bytes_left == 3'd0 && !prev_backslash))
    else $error("terminator did not re-arm string state");

endmodule

// ===== src/u8u2_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u2_fifo
// Result queue: takes up to two units per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module u8u2_fifo (
  input  logic              clk,
  input  logic              rst,
  input  u8u2_pkg::push_t   push,
  output logic              out_valid,
  input  logic              out_stall,
  output u8u2_pkg::unit_t   out_unit,
  output logic [u8u2_pkg::CNT_W-1:0] count
);
  import u8u2_pkg::*;

  unit_t              mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]   count_next;
  logic [PTR_W-1:0]   wr_ptr_p1;
  logic               pop;

  assign out_valid = (count != '0);
  assign out_unit  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr + PTR_W'(1);

  always_comb begin
    wr_ptr_next = wr_ptr + PTR_W'(push.num);
    rd_ptr_next = rd_ptr + PTR_W'(pop);
    count_next  = count + CNT_W'(push.num) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) mem[wr_ptr] <= push.u0;
    if (push.num == 2'd2) mem[wr_ptr_p1] <= push.u1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (32'(count) + 32'(push.num)) <= FIFO_DEPTH)
    else $error("result queue overflow");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    PTR_W'(wr_ptr - rd_ptr) == PTR_W'(count))
    else $error("queue pointers disagree with count");

endmodule

// ===== dv/utf8_to_ucs2_path_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_ucs2_path_decoder_top_tb
// Drives NUL-terminated UTF-8 byte streams into the decoder and checks every
// code unit against a cycle-free predictor kept in a small scoreboard. Covers
// 1 to 6 byte forms, invalid leads, broken and truncated sequences, path
// rules, and path_mode changes between phases under several idle/stall mixes.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_path_decoder_top_tb;
  import u8u2_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 190;
  localparam int LIMIT_CYCLES  = 400000;
  localparam logic [7:0] SLASH_BYTE     = SLASH[7:0];
  localparam logic [7:0] BACKSLASH_BYTE = BACKSLASH[7:0];

  class unit_scoreboard;
    bit          mode;
    logic [15:0] accum;
    logic [2:0]  left;
    bit          at_start;
    bit          prev_bs;
    unit_t       pending_units[$];
    int          errors;
    int          bytes_seen;
    int          strings_seen;
    int          units_checked;

    function new();
      accum    = '0;
      left     = '0;
      at_start = 1'b1;
    endfunction

    function void push_unit(logic [15:0] code, logic last);
      unit_t u;
      u.code = code;
      u.last = last;
      pending_units.push_back(u);
    endfunction

    function void emit_char(logic [15:0] code);
      logic [15:0] u;
      u = code;
      if (mode) begin
        if (u == SLASH) u = BACKSLASH;
        if (u == BACKSLASH && prev_bs) return;
      end
      prev_bs = (u == BACKSLASH);
      push_unit(u, 1'b0);
    endfunction

    function void note_byte(logic [7:0] b);
      bytes_seen++;
      if (at_start) begin
        at_start = 1'b0;
        if (mode) begin
          push_unit(BACKSLASH, 1'b0);
          prev_bs = 1'b1;
        end
      end
      if (b == 8'h00) begin
        accum = '0;
        left = '0;
        prev_bs = 1'b0;
        at_start = 1'b1;
        strings_seen++;
        push_unit(16'h0000, 1'b1);
        return;
      end
      if (left != 0) begin
        if (b[7:6] == 2'b10) begin
          accum = {accum[9:0], b[5:0]};
          left--;
          if (left == 0) emit_char(accum);
          return;
        end
        // broken sequence: discard and treat this byte as a fresh lead
        accum = '0;
        left = '0;
      end
      casez (b)
        8'b0???????: emit_char({8'h00, b});
        8'b110?????: begin accum = {11'd0, b[4:0]}; left = 3'd1; end
        8'b1110????: begin accum = {12'd0, b[3:0]}; left = 3'd2; end
        8'b11110???: begin accum = {13'd0, b[2:0]}; left = 3'd3; end
        8'b111110??: begin accum = {14'd0, b[1:0]}; left = 3'd4; end
        8'b1111110?: begin accum = {15'd0, b[0]};   left = 3'd5; end
        default: ;  // drop invalid lead
      endcase
    endfunction

    function void check_unit(logic [15:0] code, logic last);
      unit_t u;
      units_checked++;
      if (pending_units.size() == 0) begin
        $error("unexpected unit: code_unit %h last_unit %b", code, last);
        errors++;
        return;
      end
      u = pending_units.pop_front();
      if (code !== u.code) begin
        $error("code_unit mismatch: expected %h, actual %h", u.code, code);
        errors++;
      end
      if (last !== u.last) begin
        $error("last_unit mismatch: expected %b, actual %b", u.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_in = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] code_unit;
  logic        last_unit;

  unit_scoreboard sb;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;

  utf8_to_ucs2_path_decoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .byte_in   (byte_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_unit (code_unit),
    .last_unit (last_unit)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_byte(byte_in);
      if (out_valid && !out_stall) sb.check_unit(code_unit, last_unit);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait out every expected unit, then let bytes that make no unit clear.
  task automatic drain_units();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_units.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_path_mode(input logic m);
    drain_units();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.mode = m;
  endtask

  function automatic logic [7:0] lead_byte(int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      2: return {3'b110, r[4:0]};
      3: return {4'b1110, r[3:0]};
      4: return {5'b11110, r[2:0]};
      5: return {6'b111110, r[1:0]};
      default: return {7'b1111110, r[0]};
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 1;
    if (r < 60) return 2;
    if (r < 78) return 3;
    if (r < 90) return 4;
    if (r < 95) return 5;
    return 6;
  endfunction

  // Send one random fragment; count its bytes unless it is a single noise byte.
  task automatic send_random_chunk(inout int counted);
    logic [7:0] seq[$];
    int         pick;
    int         len;
    int         n;
    bit         noise;
    pick  = $urandom_range(99);
    noise = 1'b0;
    if (pick < 55) begin
      len = pick_len();
      if (len == 1) begin
        if ($urandom_range(3) == 0)
          seq.push_back($urandom_range(1) ? SLASH_BYTE : BACKSLASH_BYTE);
        else
          seq.push_back(8'($urandom_range(1, 127)));
      end else begin
        seq.push_back(lead_byte(len));
        repeat (len - 1) seq.push_back({2'b10, 6'($urandom)});
      end
    end else if (pick < 70) begin
      n = $urandom_range(1, 4);
      repeat (n) seq.push_back($urandom_range(1) ? SLASH_BYTE : BACKSLASH_BYTE);
    end else if (pick < 80) begin
      // truncated form: the next byte breaks it, or a terminator drops it
      len = $urandom_range(2, 6);
      seq.push_back(lead_byte(len));
      n = $urandom_range(0, len - 2);
      repeat (n) seq.push_back({2'b10, 6'($urandom)});
    end else if (pick < 88) begin
      seq.push_back(8'($urandom));
      noise = 1'b1;
    end else begin
      seq.push_back(8'h00);
    end
    foreach (seq[i]) send_byte(seq[i]);
    if (!noise) counted += seq.size();
  endtask

  initial begin
    logic [7:0] plain_seq[$];
    logic [7:0] path_seq[$];
    int         counted;
    sb = new();
    plain_seq = '{8'h41, 8'h7F, 8'hC3, 8'hA9, 8'h80, 8'hFE, 8'hFF,
                  8'hC3, 8'h41, 8'hC0, 8'h80,
                  8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
                  8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80,
                  8'hE2, 8'h00};
    path_seq  = '{8'h2F, 8'h2F, 8'h5C, 8'h61, 8'h2F, 8'h00,
                  8'hFF, 8'h00, 8'h00};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    set_path_mode(1'b0);
    foreach (plain_seq[i]) send_byte(plain_seq[i]);
    set_path_mode(1'b1);
    foreach (path_seq[i]) send_byte(path_seq[i]);

    // Alternate the mode each phase; strings are often left open across it.
    for (int phase = 0; phase < 8; phase++) begin
      set_path_mode(phase[0]);
      case (phase / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) send_random_chunk(counted);
    end

    drain_units();
    $display("Checked %0d code units from %0d bytes in %0d strings",
             sb.units_checked, sb.bytes_seen, sb.strings_seen);
    $display("Covered both path modes over free flow, sender gaps, receiver stalls, mixed");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/u8u2_pkg.sv
src/u8u2_decode.sv
src/u8u2_fifo.sv
src/utf8_to_ucs2_path_decoder_top.sv
dv/utf8_to_ucs2_path_decoder_top_tb.sv
